>>> hdl/slt_pkg.sv
// ----------------------------------------------------------------------------
// String literal transcoder package
// Beat types, status and mode codes, and the small decode helpers shared
// by the transcoder.
// ----------------------------------------------------------------------------
package slt_pkg;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       flush;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] code_unit;
        logic        last_of_run;
        logic [1:0]  status;
    } out_beat_t;

    // Result status codes.
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_HEX_NO_DIGIT = 2'd1;
    localparam logic [1:0] STATUS_BAD_UTF8     = 2'd2;

    // Unit width modes. The unused code behaves as UTF-32.
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_UTF16 = 2'd1;
    localparam logic [1:0] MODE_UTF32 = 2'd2;
    localparam logic [1:0] MODE_RESET = MODE_UTF16;

    localparam logic [31:0] SUPP_BASE    = 32'h0001_0000;
    localparam logic [15:0] HI_SURR_BASE = 16'hd800;
    localparam logic [15:0] LO_SURR_BASE = 16'hdc00;
    localparam logic [31:0] CP_MAX       = 32'h0010_ffff;
    localparam logic [31:0] SURR_FIRST   = 32'h0000_d800;
    localparam logic [31:0] SURR_LAST    = 32'h0000_dfff;
    localparam logic [31:0] MIN_CP_U2    = 32'h0000_0080;
    localparam logic [31:0] MIN_CP_U3    = 32'h0000_0800;
    localparam logic [31:0] MIN_CP_U4    = 32'h0001_0000;

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_X      = 8'h78;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Truncate a value to the selected unit width.
    function automatic logic [31:0] cut_unit(input logic [1:0] mode, input logic [31:0] v);
        logic [31:0] r;
        case (mode)
            MODE_BYTE:  r = {24'd0, v[7:0]};
            MODE_UTF16: r = {16'd0, v[15:0]};
            default:    r = v;
        endcase
        return r;
    endfunction

    // Value of a single-character escape; other bytes stand for themselves,
    // sign-extended as a signed char.
    function automatic logic [31:0] named_escape(input logic [7:0] b);
        logic [31:0] r;
        case (b)
            8'h61:   r = 32'd7;
            8'h62:   r = 32'd8;
            8'h74:   r = 32'd9;
            8'h6e:   r = 32'd10;
            8'h76:   r = 32'd11;
            8'h66:   r = 32'd12;
            8'h72:   r = 32'd13;
            default: r = {{24{b[7]}}, b};
        endcase
        return r;
    endfunction

    // Hex digit value, or 16 when the byte is not a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = 5'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = 5'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = 5'(b - 8'h37);
        end else begin
            r = 5'd16;
        end
        return r;
    endfunction

endpackage

>>> hdl/string_literal_transcoder.sv
// ----------------------------------------------------------------------------
// String literal transcoder
// Decodes escapes and UTF-8 in the body of a C string literal and emits
// 8-bit, UTF-16 or UTF-32 code units.
// ----------------------------------------------------------------------------
// One body byte per beat is taken on the s_ channel, and every cycle can take
// a new beat while the result queue has room. A beat is first captured in an
// input register and then decoded against the escape/UTF-8 state, which
// writes its zero, one or two results into a four-entry result queue; the
// first result reaches m_ through the input register and then the queue. A
// beat is decoded only when the queue has room for two results, so a beat
// that yields two results (a surrogate pair, or a pending escape closed by a
// byte that itself gives a unit) fills two queue entries, while the input side
// keeps moving as long as the queue drains. The unit width register is written
// through cfg_wr_en and cfg_wr_data; the user must write it only while no beat
// is in flight, as the block itself does not enforce this.
module string_literal_transcoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  slt_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output slt_pkg::out_beat_t m_data
);
    import slt_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BSL,
        PH_OCT,
        PH_HEX,
        PH_U2,
        PH_U3,
        PH_U4
    } phase_t;

    logic [1:0]  mode_reg;
    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  dc_reg, dc_next;
    logic [1:0]  cl_reg, cl_next;

    in_beat_t    in_reg;
    logic        in_valid_reg;

    out_beat_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   cnt_reg;

    logic        pop, fire;
    logic [FIFO_CNT_W-1:0] cnt_after_pop;

    // Decode signals
    logic [7:0]  b;
    logic        fl;
    logic [4:0]  hd;
    logic        oct_dig;
    logic [31:0] cp;
    logic [31:0] cp_off;
    logic [31:0] cp_min;
    logic        cp_ok;
    logic        put_a, put_b, idle_put, run_idle;
    logic [31:0] val_a, val_b, idle_val;
    logic [1:0]  st_a, idle_st;
    logic [1:0]  n_res;
    out_beat_t   slot0, slot1;

    assign pop           = (cnt_reg != '0) && m_ready;
    assign cnt_after_pop = cnt_reg - {{(FIFO_CNT_W-1){1'b0}}, pop};
    assign fire          = in_valid_reg && (cnt_after_pop <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign s_ready       = !in_valid_reg || fire;
    assign m_valid       = (cnt_reg != '0);
    assign m_data        = fifo_reg[rd_ptr_reg];

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dc_next    = dc_reg;
        cl_next    = cl_reg;
        put_a      = 1'b0;
        put_b      = 1'b0;
        val_a      = '0;
        val_b      = '0;
        st_a       = STATUS_OK;
        run_idle   = 1'b0;
        idle_put   = 1'b0;
        idle_val   = '0;
        idle_st    = STATUS_OK;
        b          = in_reg.body_byte;
        fl         = in_reg.flush;
        hd         = hex_digit(b);
        oct_dig    = (b >= 8'h30) && (b <= 8'h37);
        cp         = {acc_reg[25:0], b[5:0]};
        cp_off     = cp - SUPP_BASE;
        case (phase_reg)
            PH_U2:   cp_min = MIN_CP_U2;
            PH_U3:   cp_min = MIN_CP_U3;
            default: cp_min = MIN_CP_U4;
        endcase
        cp_ok = (cp >= cp_min) && (cp <= CP_MAX) && !((cp >= SURR_FIRST) && (cp <= SURR_LAST));

        case (phase_reg)
            PH_BSL: begin
                phase_next = PH_IDLE;
                acc_next   = '0;
                dc_next    = '0;
                cl_next    = '0;
                if (!fl) begin
                    if (oct_dig) begin
                        phase_next = PH_OCT;
                        acc_next   = {29'd0, b[2:0]};
                        dc_next    = 2'd1;
                    end else if (b == CH_X) begin
                        phase_next = PH_HEX;
                    end else begin
                        put_a = 1'b1;
                        val_a = cut_unit(mode_reg, named_escape(b));
                    end
                end
            end
            PH_OCT: begin
                if (!fl && oct_dig) begin
                    acc_next = {acc_reg[28:0], b[2:0]};
                    dc_next  = dc_reg + 2'd1;
                    if (dc_next == 2'd3 || dc_next == 2'd0) begin
                        put_a      = 1'b1;
                        val_a      = cut_unit(mode_reg, acc_next);
                        phase_next = PH_IDLE;
                        acc_next   = '0;
                        dc_next    = '0;
                        cl_next    = '0;
                    end
                end else begin
                    put_a      = 1'b1;
                    val_a      = cut_unit(mode_reg, acc_reg);
                    phase_next = PH_IDLE;
                    acc_next   = '0;
                    dc_next    = '0;
                    cl_next    = '0;
                    run_idle   = !fl;
                end
            end
            PH_HEX: begin
                if (!fl && !hd[4]) begin
                    acc_next = {acc_reg[27:0], hd[3:0]};
                    dc_next  = 2'd1;
                end else begin
                    put_a      = 1'b1;
                    phase_next = PH_IDLE;
                    acc_next   = '0;
                    dc_next    = '0;
                    cl_next    = '0;
                    if (dc_reg == 2'd0) begin
                        // The offending byte is dropped after the error.
                        st_a = STATUS_HEX_NO_DIGIT;
                    end else begin
                        val_a    = cut_unit(mode_reg, acc_reg);
                        run_idle = !fl;
                    end
                end
            end
            PH_U2, PH_U3, PH_U4: begin
                if (fl || b[7:6] != 2'b10 || cl_reg == 2'd0) begin
                    put_a      = 1'b1;
                    st_a       = STATUS_BAD_UTF8;
                    phase_next = PH_IDLE;
                    acc_next   = '0;
                    dc_next    = '0;
                    cl_next    = '0;
                end else begin
                    acc_next = cp;
                    cl_next  = cl_reg - 2'd1;
                    if (cl_next == 2'd0) begin
                        put_a      = 1'b1;
                        phase_next = PH_IDLE;
                        acc_next   = '0;
                        dc_next    = '0;
                        if (!cp_ok) begin
                            st_a = STATUS_BAD_UTF8;
                        end else if (mode_reg == MODE_UTF16 && cp >= SUPP_BASE) begin
                            put_b = 1'b1;
                            val_a = {16'd0, HI_SURR_BASE + {6'd0, cp_off[19:10]}};
                            val_b = {16'd0, LO_SURR_BASE + {6'd0, cp_off[9:0]}};
                        end else begin
                            val_a = cut_unit(mode_reg, cp);
                        end
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
                acc_next   = '0;
                dc_next    = '0;
                cl_next    = '0;
                run_idle   = !fl;
            end
        endcase

        // A byte seen with no escape or sequence pending.
        if (run_idle) begin
            if (b == CH_BSLASH) begin
                phase_next = PH_BSL;
            end else if (mode_reg == MODE_BYTE || !b[7]) begin
                idle_put = 1'b1;
                idle_val = {24'd0, b};
            end else if (b[7:5] == 3'b110) begin
                phase_next = PH_U2;
                acc_next   = {27'd0, b[4:0]};
                cl_next    = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                phase_next = PH_U3;
                acc_next   = {28'd0, b[3:0]};
                cl_next    = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                phase_next = PH_U4;
                acc_next   = {29'd0, b[2:0]};
                cl_next    = 2'd3;
            end else begin
                idle_put = 1'b1;
                idle_st  = STATUS_BAD_UTF8;
            end
        end

        n_res = {1'b0, put_a} + {1'b0, put_b} + {1'b0, idle_put};

        slot0.code_unit   = put_a ? val_a : idle_val;
        slot0.status      = put_a ? st_a : idle_st;
        slot0.last_of_run = (n_res == 2'd1);
        slot1.code_unit   = put_b ? val_b : idle_val;
        slot1.status      = put_b ? STATUS_OK : idle_st;
        slot1.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_RESET;
            phase_reg    <= PH_IDLE;
            acc_reg      <= '0;
            dc_reg       <= '0;
            cl_reg       <= '0;
            in_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                dc_reg     <= dc_next;
                cl_reg     <= cl_next;
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            cnt_reg <= cnt_after_pop + (fire ? FIFO_CNT_W'(n_res) : '0);
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire && n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= slot0;
        end
        if (fire && n_res == 2'd2) begin
            fifo_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= slot1;
        end
    end

    // The queue never holds more entries than it has.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    // With nothing pending, the decode state is fully cleared.
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (acc_reg == '0 && dc_reg == '0 && cl_reg == '0))
        else $error("idle phase with leftover decode state");

    // A UTF-8 sequence in progress always expects more continuation bytes.
    a_utf8_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_U2 || phase_reg == PH_U3 || phase_reg == PH_U4) |-> (cl_reg != '0))
        else $error("UTF-8 phase with no continuation bytes left");

    // Error results carry a zero code unit.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_OK) |-> (m_data.code_unit == '0))
        else $error("error result with nonzero code unit");

    // A beat that waits in the input register is decoded once the queue drains.
    a_fire_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && cnt_reg == '0) |-> fire)
        else $error("input beat stalled with an empty result queue");

endmodule

>>> bench/slt_transcode_checker.sv
// ----------------------------------------------------------------------------
// String literal transcoder result checker
// Watches the configuration port and both beat channels, predicts the code
// units that each accepted body beat produces, and compares every result
// beat against the oldest prediction.
// ----------------------------------------------------------------------------
module slt_transcode_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  slt_pkg::in_beat_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  slt_pkg::out_beat_t m_data,
    output int                 mismatches,
    output int                 waiting,
    output int                 checked
);
    import slt_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BACKSLASH,
        PH_OCTAL,
        PH_HEX,
        PH_UTF8_2,
        PH_UTF8_3,
        PH_UTF8_4
    } decode_phase_e;

    // Predicted decoder state; the unit mode is mirrored from the configuration writes.
    logic [1:0]    unit_mode;
    decode_phase_e phase;
    logic [31:0]   accum;
    logic [1:0]    digits;
    logic [1:0]    cont_left;

    out_beat_t step_units [2];
    int        step_count;
    out_beat_t expected_units [$];
    out_beat_t want;
    out_beat_t got;

    function automatic logic [31:0] fit_unit(logic [31:0] v);
        case (unit_mode)
            MODE_BYTE:  return v & 32'h0000_00ff;
            MODE_UTF16: return v & 32'h0000_ffff;
            default:    return v;
        endcase
    endfunction

    function automatic logic [31:0] escape_value(logic [7:0] b);
        case (b)
            "a":     return 32'd7;
            "b":     return 32'd8;
            "t":     return 32'd9;
            "n":     return 32'd10;
            "v":     return 32'd11;
            "f":     return 32'd12;
            "r":     return 32'd13;
            default: return 32'($signed(b));
        endcase
    endfunction

    // Returns 16 for a byte that is not a hex digit.
    function automatic logic [4:0] nibble_of(logic [7:0] b);
        if (b >= "0" && b <= "9") begin
            return {1'b0, b[3:0]};
        end
        if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
            return {1'b0, b[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    function automatic void add_result(logic [31:0] v, logic [1:0] st);
        if (step_count < 2) begin
            step_units[step_count] = '{code_unit: v, last_of_run: 1'b0, status: st};
            step_count++;
        end
    endfunction

    function automatic void add_code_point(logic [31:0] cp);
        logic [31:0] c;
        if (unit_mode == MODE_UTF16 && cp >= SUPP_BASE) begin
            c = cp - SUPP_BASE;
            add_result({16'd0, HI_SURR_BASE} + {22'd0, c[19:10]}, STATUS_OK);
            add_result({16'd0, LO_SURR_BASE} + {22'd0, c[9:0]}, STATUS_OK);
        end else begin
            add_result(fit_unit(cp), STATUS_OK);
        end
    endfunction

    function automatic void clear_state();
        phase = PH_IDLE;
        accum = '0;
        digits = '0;
        cont_left = '0;
    endfunction

    // A byte seen with no escape or UTF-8 sequence pending.
    function automatic void start_plain(logic [7:0] b);
        clear_state();
        if (b == CH_BSLASH) begin
            phase = PH_BACKSLASH;
        end else if (unit_mode == MODE_BYTE || !b[7]) begin
            add_result({24'd0, b}, STATUS_OK);
        end else if (b[7:5] == 3'b110) begin
            phase = PH_UTF8_2;
            accum = {27'd0, b[4:0]};
            cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            phase = PH_UTF8_3;
            accum = {28'd0, b[3:0]};
            cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            phase = PH_UTF8_4;
            accum = {29'd0, b[2:0]};
            cont_left = 2'd3;
        end else begin
            add_result('0, STATUS_BAD_UTF8);
        end
    endfunction

    function automatic void transcode_beat(in_beat_t beat);
        logic [7:0]  b;
        logic        fl;
        logic [4:0]  nib;
        logic [31:0] lowest;
        b = beat.body_byte;
        fl = beat.flush;
        step_count = 0;
        case (phase)
            PH_BACKSLASH: begin
                clear_state();
                if (!fl) begin
                    if (b >= "0" && b <= "7") begin
                        phase = PH_OCTAL;
                        accum = {29'd0, b[2:0]};
                        digits = 2'd1;
                    end else if (b == CH_X) begin
                        phase = PH_HEX;
                    end else begin
                        add_result(fit_unit(escape_value(b)), STATUS_OK);
                    end
                end
            end
            PH_OCTAL: begin
                if (!fl && b >= "0" && b <= "7") begin
                    accum = {accum[28:0], b[2:0]};
                    digits = digits + 2'd1;
                    if (digits == 2'd3 || digits == 2'd0) begin
                        add_result(fit_unit(accum), STATUS_OK);
                        clear_state();
                    end
                end else begin
                    add_result(fit_unit(accum), STATUS_OK);
                    clear_state();
                    if (!fl) start_plain(b);
                end
            end
            PH_HEX: begin
                nib = nibble_of(b);
                if (!fl && !nib[4]) begin
                    accum = {accum[27:0], nib[3:0]};
                    digits = 2'd1;
                end else if (digits == 2'd0) begin
                    add_result('0, STATUS_HEX_NO_DIGIT);
                    clear_state();
                end else begin
                    add_result(fit_unit(accum), STATUS_OK);
                    clear_state();
                    if (!fl) start_plain(b);
                end
            end
            PH_UTF8_2, PH_UTF8_3, PH_UTF8_4: begin
                if (fl || b[7:6] != 2'b10 || cont_left == 2'd0) begin
                    add_result('0, STATUS_BAD_UTF8);
                    clear_state();
                end else begin
                    accum = {accum[25:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        lowest = (phase == PH_UTF8_2) ? MIN_CP_U2 :
                                 (phase == PH_UTF8_3) ? MIN_CP_U3 : MIN_CP_U4;
                        // Overlong forms, surrogates and values past the last
                        // code point are all rejected the same way.
                        if (accum >= lowest && accum <= CP_MAX &&
                            !(accum >= SURR_FIRST && accum <= SURR_LAST)) begin
                            add_code_point(accum);
                        end else begin
                            add_result('0, STATUS_BAD_UTF8);
                        end
                        clear_state();
                    end
                end
            end
            default: begin
                clear_state();
                if (!fl) start_plain(b);
            end
        endcase
        for (int i = 0; i < step_count; i++) begin
            want = step_units[i];
            want.last_of_run = (i == step_count - 1);
            expected_units.push_back(want);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            unit_mode = MODE_RESET;
            clear_state();
            expected_units.delete();
            mismatches = 0;
            checked = 0;
        end else begin
            if (cfg_wr_en) unit_mode = cfg_wr_data;
            if (m_valid && m_ready) begin
                got = m_data;
                checked++;
                if (expected_units.size() == 0) begin
                    $error("unexpected result beat: code_unit %h last_of_run %b status %0d",
                           got.code_unit, got.last_of_run, got.status);
                    mismatches++;
                end else begin
                    want = expected_units.pop_front();
                    if (got.code_unit !== want.code_unit) begin
                        $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
                        mismatches++;
                    end
                    if (got.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, got %b",
                               want.last_of_run, got.last_of_run);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) transcode_beat(s_data);
        end
        waiting = expected_units.size();
    end

endmodule

>>> bench/tb_string_literal_transcoder.sv
// ----------------------------------------------------------------------------
// String literal transcoder testbench
// Feeds directed and random literal bodies (escapes, UTF-8, broken input,
// flushes) in every unit width mode under varied sender and receiver
// pacing, and leaves the checking to the result checker.
// ----------------------------------------------------------------------------
module tb_string_literal_transcoder;
    import slt_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASE_BEATS = 80;
    localparam int         N_PHASES    = 8;
    localparam int         LONG_HOLD   = 200;
    localparam int         PRESSURE_PH = 4;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [1:0] cfg_wr_data = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_beat_t   s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_beat_t  m_data;

    int   mismatches;
    int   waiting;
    int   checked;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic long_hold_req  = 1'b0;
    int   hold_cycles    = 0;
    int   cycle_count    = 0;
    int   beats_sent     = 0;

    logic [1:0] phase_mode [N_PHASES] = '{MODE_UTF16, MODE_BYTE, MODE_UTF32, MODE_SPARE,
                                          MODE_UTF16, MODE_BYTE, MODE_UTF32, MODE_UTF16};
    int phase_idle  [N_PHASES] = '{0, 71, 0, 37, 0, 37, 71, 0};
    int phase_stall [N_PHASES] = '{0, 0, 71, 37, 0, 37, 0, 71};

    string hex_chars   = "0123456789abcdefABCDEF";
    string named_chars = "abtnvfr";

    string_literal_transcoder u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    slt_transcode_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .waiting     (waiting),
        .checked     (checked)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.", waiting);
            $display("[string_literal_transcoder] ERROR");
            $finish;
        end
    end

    // Receiver pacing; the long hold-off lets the result queue fill up and
    // back-pressure the input side.
    always @(negedge aclk) begin
        if (long_hold_req && hold_cycles < LONG_HOLD) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_beat(in_beat_t b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_beat('{body_byte: b, flush: 1'b0});
    endtask

    task automatic send_flush();
        send_beat('{body_byte: 8'($urandom), flush: 1'b1});
    endtask

    task automatic send_utf8(logic [31:0] cp, int len);
        case (len)
            1: begin
                send_byte(cp[7:0]);
            end
            2: begin
                send_byte({3'b110, cp[10:6]});
                send_byte({2'b10, cp[5:0]});
            end
            3: begin
                send_byte({4'b1110, cp[15:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
            default: begin
                send_byte({5'b11110, cp[20:18]});
                send_byte({2'b10, cp[17:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic send_random_token();
        int          pick;
        int          len;
        int          n;
        logic [7:0]  b;
        logic [31:0] cp;
        pick = $urandom_range(99);
        if (pick < 22) begin
            b = 8'($urandom_range(127));
            send_byte(b == CH_BSLASH ? 8'("A") : b);
        end else if (pick < 32) begin
            send_byte(CH_BSLASH);
            if ($urandom_range(3) == 0) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(named_chars[$urandom_range(6)]);
            end
        end else if (pick < 42) begin
            send_byte(CH_BSLASH);
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) send_byte("0" + 8'($urandom_range(7)));
        end else if (pick < 54) begin
            send_byte(CH_BSLASH);
            send_byte(CH_X);
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
            for (int i = 0; i < n; i++) send_byte(hex_chars[$urandom_range(21)]);
        end else if (pick < 76) begin
            len = $urandom_range(1, 4);
            case (len)
                1: cp = $urandom_range(32'h7f);
                2: cp = $urandom_range(32'h80, 32'h7ff);
                3: begin
                    cp = $urandom_range(32'h800, 32'hffff);
                    if (cp >= SURR_FIRST && cp <= SURR_LAST) cp = cp + 32'h800;
                end
                default: cp = $urandom_range(32'h10000, 32'h10ffff);
            endcase
            send_utf8(cp, len);
        end else if (pick < 86) begin
            case ($urandom_range(6))
                0: send_byte(8'($urandom_range(8'h80, 8'hbf)));
                1: send_byte(8'($urandom_range(8'hf8, 8'hff)));
                2: begin
                    send_byte(8'($urandom_range(8'hc0, 8'hf7)));
                    send_byte(8'($urandom_range(8'h00, 8'h7f)) | 8'($urandom_range(1) << 6));
                end
                3: begin
                    len = $urandom_range(2, 4);
                    cp = $urandom_range(len == 2 ? 32'h7f : len == 3 ? 32'h7ff : 32'hffff);
                    send_utf8(cp, len);
                end
                4: send_utf8($urandom_range(SURR_FIRST, SURR_LAST), 3);
                5: send_utf8($urandom_range(32'h110000, 32'h1fffff), 4);
                default: begin
                    // Sequence cut short by the end of the literal.
                    send_byte(8'($urandom_range(8'hc0, 8'hf7)));
                    if ($urandom_range(1)) send_byte(8'($urandom_range(8'h80, 8'hbf)));
                    send_flush();
                end
            endcase
        end else if (pick < 92) begin
            send_flush();
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (waiting != 0) @(negedge aclk);
        // A beat with no result may still be inside the pipeline.
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_mode(logic [1:0] m);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int target;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part in the reset mode.
        send_byte(CH_BSLASH); send_byte("n");
        send_byte(CH_BSLASH); send_byte(8'hff);
        send_byte(CH_BSLASH); send_byte("1"); send_byte("2"); send_byte("3");
        send_byte(CH_BSLASH); send_byte("7"); send_byte("z");
        send_byte(CH_BSLASH); send_byte(CH_X); send_byte("A"); send_byte("f");
        send_flush();
        send_byte(CH_BSLASH); send_byte(CH_X); send_byte("g");
        send_utf8(32'h1f600, 4);
        send_byte(8'h80);
        send_byte(CH_BSLASH); send_flush();
        send_flush();
        wait_drained();

        target = beats_sent;
        for (int p = 0; p < N_PHASES; p++) begin
            write_mode(phase_mode[p]);
            send_idle_pct <= phase_idle[p];
            recv_stall_pct <= phase_stall[p];
            if (p == PRESSURE_PH) long_hold_req <= 1'b1;
            target += PHASE_BEATS;
            while (beats_sent < target) send_random_token();
            wait_drained();
        end

        $display("Sent %0d body beats in a directed part and %0d random phases; %0d results checked.",
                 beats_sent, N_PHASES, checked);
        if (mismatches == 0) begin
            $display("[string_literal_transcoder] OK");
        end else begin
            $display("[string_literal_transcoder] ERROR");
        end
        $finish;
    end

endmodule
